// ===== hdl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue and its storage cells.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] key;
  } entry_t;

  typedef struct packed {
    logic   shift_in;
    logic   shift_out;
    entry_t item;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One storage slot of the sorted chain: compares its key with the incoming
// key and takes the new entry, its left neighbor, or its right neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell (
  input  wire logic               clk_i,
  input  wire spq_pkg::cell_ctrl_t ctrl_i,
  input  wire logic               occ_i,
  input  wire logic               left_gt_i,
  input  wire spq_pkg::entry_t    left_entry_i,
  input  wire spq_pkg::entry_t    right_entry_i,
  output logic                    gt_o,
  output spq_pkg::entry_t         entry_o
);

  spq_pkg::entry_t entry_q;
  spq_pkg::entry_t entry_d;

  assign gt_o    = !occ_i || !($signed(entry_q.key) < $signed(ctrl_i.item.key));
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_in) begin
      if (gt_o && left_gt_i) begin
        entry_d = left_entry_i;
      end else if (gt_o) begin
        entry_d = ctrl_i.item;
      end
    end else if (ctrl_i.shift_out) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

// ===== hdl/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept in ascending key order in a chain of cells.
// ----------------------------------------------------------------------------
// channel | direction | handshake              | beat
// in      | input     | in_valid_i / in_stall_o | opcode, item_value, item_priority
// out     | output    | out_valid_o / out_stall_i | out_value, out_priority,
//         |           |                        | status, occupancy
//
// One beat per cycle while not stalled: every cell compares its key with
// the incoming key in parallel, and the chain shifts one place in the same
// cycle. Each result reaches the output register in the cycle after its beat.
// Reset clears the entry count and the output valid; cell contents are kept.
// A stalled result holds the input side only while the output register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue #(
  parameter int CAPACITY = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               opcode_i,
  input  wire logic signed [31:0] item_value_i,
  input  wire logic signed [15:0] item_priority_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      out_value_o,
  output logic signed [15:0]      out_priority_o,
  output logic [1:0]              status_o,
  output logic [4:0]              occupancy_o
);

  localparam int CW = $clog2(CAPACITY + 1);

  logic [CW-1:0]        count_q, count_d;
  logic                 out_valid_q;
  logic signed [31:0]   out_value_q, out_value_d;
  logic signed [15:0]   out_priority_q, out_priority_d;
  spq_pkg::status_e     status_q, status_d;

  logic                 in_acc;
  logic                 full, empty;
  spq_pkg::cell_ctrl_t  ctrl;
  spq_pkg::entry_t      cell_entry [CAPACITY];
  logic                 cell_gt    [CAPACITY];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CW'(CAPACITY));
  assign empty      = (count_q == '0);

  always_comb begin
    ctrl.item.value = item_value_i;
    ctrl.item.key   = item_priority_i;
    ctrl.shift_in   = in_acc && (spq_pkg::op_e'(opcode_i) == spq_pkg::OP_INSERT) && !full;
    ctrl.shift_out  = in_acc && (spq_pkg::op_e'(opcode_i) == spq_pkg::OP_REMOVE) && !empty;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;
    logic            left_gt;

    if (i == 0) begin : g_head
      assign left_entry = ctrl.item;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_entry = cell_entry[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_entry = cell_entry[i];
    end else begin : g_inner
      assign right_entry = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occ_i         (count_q > CW'(i)),
      .left_gt_i     (left_gt),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .gt_o          (cell_gt[i]),
      .entry_o       (cell_entry[i])
    );
  end

  always_comb begin
    count_d        = count_q;
    out_value_d    = out_value_q;
    out_priority_d = out_priority_q;
    status_d       = status_q;
    if (in_acc) begin
      out_value_d    = '0;
      out_priority_d = '0;
      unique case (spq_pkg::op_e'(opcode_i))
        spq_pkg::OP_INSERT: begin
          if (full) begin
            status_d = spq_pkg::ST_FULL;
          end else begin
            status_d = spq_pkg::ST_INSERTED;
            count_d  = count_q + CW'(1);
          end
        end
        spq_pkg::OP_REMOVE: begin
          if (empty) begin
            status_d = spq_pkg::ST_EMPTY;
          end else begin
            status_d       = spq_pkg::ST_REMOVED;
            count_d        = count_q - CW'(1);
            out_value_d    = cell_entry[0].value;
            out_priority_d = cell_entry[0].key;
          end
        end
        default: status_d = status_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q    <= out_value_d;
    out_priority_q <= out_priority_d;
    status_q       <= status_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_value_o    = out_value_q;
  assign out_priority_o = out_priority_q;
  assign status_o       = status_q;

  logic [CW+4:0] count_d_wide;
  logic [4:0]    occupancy_q;

  assign count_d_wide = {5'd0, count_d};

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      occupancy_q <= count_d_wide[4:0];
    end
  end

  assign occupancy_o = occupancy_q;

endmodule

`default_nettype wire
